>>> rtl/core/sha1sh_pkg.sv
// Shared types and constants for the SHA-1 stream hasher core.
// Used by sha1sh_ctrl, sha1sh_datapath and sha1_stream_hasher_core; no dependencies.
`timescale 1ns / 1ps

package sha1sh_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int FILL_W      = $clog2(BLOCK_BYTES);
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = 7;
   localparam int DIGEST_N    = 5;
   localparam int WORD_IDX_W  = 3;
   localparam int LEN_W       = 64;

   localparam logic [ROUND_W-1:0]    LAST_ROUND = ROUND_W'(ROUNDS - 1);
   localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(DIGEST_N - 1);
   localparam logic [FILL_W-1:0]     FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
   localparam logic [FILL_W-1:0]     FILL_LEN   = FILL_W'(BLOCK_BYTES - 8);

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] K_CH   = 32'h5a827999;
   localparam logic [31:0] K_PAR1 = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
   localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

   localparam logic [31:0] INIT_CHAIN [DIGEST_N] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_MARK,
      ST_ZERO,
      ST_LEN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RF_CH,
      RF_PAR1,
      RF_MAJ,
      RF_PAR2
   } round_fn_type;

   typedef enum logic [1:0] {
      BS_INPUT,
      BS_MARK,
      BS_ZERO,
      BS_LENGTH
   } byte_sel_type;

   typedef struct packed {
      logic                  push;
      byte_sel_type          byte_sel;
      logic                  len_inc;
      logic                  round_load;
      logic                  round_step;
      round_fn_type          round_fn;
      logic                  fold;
      logic                  chain_init;
      logic                  out_load;
      logic [WORD_IDX_W-1:0] word_sel;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_at_len;
   } status_type;

endpackage

>>> rtl/core/sha1sh_datapath.sv
// Datapath of the SHA-1 stream hasher: message window, round registers,
// chaining words, fill count, bit length and digest output register. Uses sha1sh_pkg.
`timescale 1ns / 1ps

module sha1sh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_data_byte,
   input  sha1sh_pkg::cmd_type  cmd,
   output sha1sh_pkg::status_type status,
   output logic [31:0]          rsp_digest_word
);
   import sha1sh_pkg::*;

   logic [31:0]       window_ff [16];
   logic [31:0]       window_in [16];
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [31:0]       chain_ff [DIGEST_N];
   logic [31:0]       chain_in [DIGEST_N];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  bitlen_ff, bitlen_in;
   logic [31:0]       digest_ff, digest_in;

   logic [7:0]        push_byte;
   logic [LEN_W-1:0]  len_shift;
   logic [31:0]       w_next;
   logic [31:0]       f_val;
   logic [31:0]       k_val;
   logic [31:0]       t_val;

   assign status.fill_last   = (fill_ff == FILL_LAST);
   assign status.fill_at_len = (fill_ff == FILL_LEN);

   // Length bytes go out most significant first, one per fill slot 56..63.
   assign len_shift = bitlen_ff >> {3'(~fill_ff[2:0]), 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BS_INPUT:  push_byte = req_data_byte;
         BS_MARK:   push_byte = PAD_MARK;
         BS_ZERO:   push_byte = 8'h00;
         BS_LENGTH: push_byte = len_shift[7:0];
         default:   push_byte = 8'h00;
      endcase
   end

   assign w_next = {window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0]} << 1 |
                   {31'd0, window_ff[13][31] ^ window_ff[8][31] ^ window_ff[2][31] ^
                    window_ff[0][31]};

   always_comb begin
      case (cmd.round_fn)
         RF_CH: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_CH;
         end
         RF_PAR1: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR1;
         end
         RF_MAJ: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_MAJ;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR2;
         end
      endcase
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + window_ff[0];

   // Window: bytes shift in at the tail; rounds shift words toward slot 0.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         window_in[i] = window_ff[i];
      end
      if (cmd.push) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = {window_ff[i][23:0], window_ff[i+1][31:24]};
         end
         window_in[15] = {window_ff[15][23:0], push_byte};
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[15] = w_next;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.round_load) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_step) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < DIGEST_N; i++) begin
         chain_in[i] = chain_ff[i];
      end
      if (cmd.chain_init) begin
         for (int i = 0; i < DIGEST_N; i++) begin
            chain_in[i] = INIT_CHAIN[i];
         end
      end else if (cmd.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   assign fill_in = cmd.push ? fill_ff + FILL_W'(1) : fill_ff;

   always_comb begin
      bitlen_in = bitlen_ff;
      if (cmd.chain_init) begin
         bitlen_in = '0;
      end else if (cmd.len_inc) begin
         bitlen_in = bitlen_ff + LEN_W'(8);
      end
   end

   always_comb begin
      digest_in = digest_ff;
      if (cmd.out_load) begin
         case (cmd.word_sel)
            3'd0:    digest_in = chain_ff[0];
            3'd1:    digest_in = chain_ff[1];
            3'd2:    digest_in = chain_ff[2];
            3'd3:    digest_in = chain_ff[3];
            default: digest_in = chain_ff[4];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         window_ff[i] <= window_in[i];
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
      digest_ff <= digest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGEST_N; i++) begin
            chain_ff[i] <= INIT_CHAIN[i];
         end
         fill_ff   <= '0;
         bitlen_ff <= '0;
      end else begin
         for (int i = 0; i < DIGEST_N; i++) begin
            chain_ff[i] <= chain_in[i];
         end
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
      end
   end

   assign rsp_digest_word = digest_ff;

endmodule

>>> rtl/core/sha1sh_ctrl.sv
// Controller of the SHA-1 stream hasher: sequences byte intake, rounds,
// padding and digest transfer, and owns the result handshake. Uses sha1sh_pkg.
`timescale 1ns / 1ps

module sha1sh_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_byte_present,
   input  logic                             req_end_of_message,
   output logic                             req_stall,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [sha1sh_pkg::WORD_IDX_W-1:0] rsp_word_index,
   output logic                             rsp_last_word,
   input  sha1sh_pkg::status_type           status,
   output sha1sh_pkg::cmd_type              cmd
);
   import sha1sh_pkg::*;

   state_type             state_ff, state_in;
   state_type             resume_ff, resume_in;
   logic [ROUND_W-1:0]    round_ff, round_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic accept;
   logic slot_free;

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_present && status.fill_last) begin
                  state_in  = ST_ROUND;
                  resume_in = req_end_of_message ? ST_MARK : ST_IDLE;
               end else if (req_end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = resume_ff;
         end
         ST_MARK: begin
            if (status.fill_last) begin
               state_in  = ST_ROUND;
               resume_in = ST_ZERO;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.fill_at_len) begin
               state_in = ST_LEN;
            end else if (status.fill_last) begin
               state_in  = ST_ROUND;
               resume_in = ST_ZERO;
            end
         end
         ST_LEN: begin
            if (status.fill_last) begin
               state_in  = ST_ROUND;
               resume_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free && word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd            = '0;
      cmd.byte_sel   = BS_INPUT;
      cmd.round_fn   = RF_CH;
      cmd.word_sel   = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.push    = accept && req_byte_present;
            cmd.len_inc = accept && req_byte_present;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_MARK: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = BS_MARK;
         end
         ST_ZERO: begin
            cmd.push     = !status.fill_at_len;
            cmd.byte_sel = BS_ZERO;
         end
         ST_LEN: begin
            cmd.push     = 1'b1;
            cmd.byte_sel = BS_LENGTH;
         end
         ST_EMIT: begin
            cmd.out_load   = slot_free;
            cmd.chain_init = slot_free && (word_ff == LAST_WORD);
         end
         default: ;
      endcase
      cmd.round_load = cmd.push && status.fill_last;
      if (round_ff < ROUND_W'(20)) begin
         cmd.round_fn = RF_CH;
      end else if (round_ff < ROUND_W'(40)) begin
         cmd.round_fn = RF_PAR1;
      end else if (round_ff < ROUND_W'(60)) begin
         cmd.round_fn = RF_MAJ;
      end else begin
         cmd.round_fn = RF_PAR2;
      end
   end

   always_comb begin
      round_in = round_ff;
      if (state_ff == ST_ROUND) begin
         round_in = (round_ff == LAST_ROUND) ? '0 : round_ff + ROUND_W'(1);
      end
   end

   // Result register: reload on each free slot in emit, hold while stalled.
   always_comb begin
      word_in      = word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = word_ff;
         rsp_last_in  = (word_ff == LAST_WORD);
         word_in      = (word_ff == LAST_WORD) ? '0 : word_ff + WORD_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resume_ff    <= ST_IDLE;
         round_ff     <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_last_word  = rsp_last_ff;

endmodule

>>> rtl/core/sha1_stream_hasher_core.sv
// Top level of the SHA-1 stream hasher: joins controller and datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall  | data_byte, byte_present, end_of_message
//   rsp     | out       | rsp_valid/rsp_stall  | digest_word, word_index, last_word
//
// A byte item is one transfer; the 64th byte of a block is followed by the compression
// (80 rounds on one round unit, then one chaining add) before the next transfer.
// An end item pads one byte per cycle (9 to 64 bytes, or 65 to 72 when a second
// block is needed) with a pause at the length slot, runs each padded block as
// above, then moves five digest words, one per free cycle.
// Reset is synchronous; it restores the initial chaining words and clears the
// length and fill count. A stalled result holds; a new item is taken once all five
// words are loaded into the result register.
`timescale 1ns / 1ps

module sha1_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1sh_pkg::*;

   cmd_type    cmd;
   status_type status;

   sha1sh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .req_stall          (req_stall),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .status             (status),
      .cmd                (cmd)
   );

   sha1sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

>>> tb/sha1_digest_checker.sv
// Digest checker for the SHA-1 stream hasher: watches the req and rsp channels,
// hashes every accepted item on its own and compares each digest word in order.
// Standalone; no package or RTL dependencies.
`timescale 1ns / 1ps

module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          mismatch_count,
   output int          words_due
);

   localparam logic [31:0] SHA_K0 = 32'h5a827999;
   localparam logic [31:0] SHA_K1 = 32'h6ed9eba1;
   localparam logic [31:0] SHA_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] SHA_K3 = 32'hca62c1d6;
   localparam logic [31:0] SHA_IV [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   digest_word_type digest_words_due [$];
   logic [31:0]   chain_h [5];
   logic [7:0]    block_bytes [64];
   int            fill_level;
   logic [63:0]   msg_bits;
   int            errors = 0;
   int            due_q  = 0;

   assign mismatch_count = errors;
   assign words_due      = due_q;

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, wn;
      int i, r;
      for (i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                 block_bytes[4*i+2], block_bytes[4*i+3]};
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (r = 0; r < 80; r++) begin
         if (r >= 16) begin
            wn = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
            wn = {wn[30:0], wn[31]};
            w[r & 15] = wn;
         end else begin
            wn = w[r];
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = SHA_K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = SHA_K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = SHA_K2;
         end else begin
            f = b ^ c ^ d;
            k = SHA_K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + wn;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endtask

   task automatic absorb_byte(input logic [7:0] v);
      block_bytes[fill_level] = v;
      fill_level++;
      if (fill_level == 64) begin
         compress_block();
         fill_level = 0;
      end
   endtask

   task automatic restart_hash();
      int i;
      for (i = 0; i < 5; i++)
         chain_h[i] = SHA_IV[i];
      fill_level = 0;
      msg_bits   = '0;
   endtask

   task automatic hash_item(input logic [7:0] v, input logic present, input logic last);
      logic [63:0]     bits;
      digest_word_type dw;
      int i;
      if (present) begin
         msg_bits += 64'd8;
         absorb_byte(v);
      end
      if (last) begin
         bits = msg_bits;
         absorb_byte(8'h80);
         while (fill_level != 56)
            absorb_byte(8'h00);
         for (i = 0; i < 8; i++)
            absorb_byte(bits[63 - 8*i -: 8]);
         for (i = 0; i < 5; i++) begin
            dw.word  = chain_h[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            digest_words_due.push_back(dw);
         end
         restart_hash();
      end
   endtask

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         restart_hash();
         digest_words_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_words_due.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected digest word %h idx %0d last %0b", $realtime,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
               errors++;
            end else begin
               exp_w = digest_words_due.pop_front();
               if (rsp_digest_word !== exp_w.word || rsp_word_index !== exp_w.index ||
                   rsp_last_word !== exp_w.last) begin
                  if (errors < 10)
                     $display({"%0t: digest mismatch: expected %h idx %0d last %0b, ",
                               "got %h idx %0d last %0b"},
                              $realtime, exp_w.word, exp_w.index, exp_w.last,
                              rsp_digest_word, rsp_word_index, rsp_last_word);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            hash_item(req_data_byte, req_byte_present, req_end_of_message);
      end
      // publish after the update through a register, so the sender reads the updated count
      due_q <= digest_words_due.size();
   end

endmodule

>>> tb/testbench.sv
// Top of the SHA-1 stream hasher testbench: clock, reset, message stimulus and verdict.
// Depends on sha1_stream_hasher_core and sha1_digest_checker.
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_byte_present;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          mismatch_count;
   int          words_due;

   int          items_sent    = 0;
   int          messages_sent = 0;
   int          burst_left    = 0;
   int          stall_phase   = 0;
   int          stall_mode    = 0;

   sha1_stream_hasher_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   sha1_digest_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .mismatch_count     (mismatch_count),
      .words_due          (words_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: switch between free flow, random, toggling and heavy stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_phase <= 0;
      end else begin
         if (stall_phase == 0) begin
            stall_phase <= $urandom_range(10, 60);
            stall_mode  <= $urandom_range(0, 3);
         end else begin
            stall_phase <= stall_phase - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ~rsp_stall;
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic send_item(input logic [7:0] v, input logic present, input logic last);
      pace_sender();
      req_valid          <= 1'b1;
      req_data_byte      <= v;
      req_byte_present   <= present;
      req_end_of_message <= last;
      // hold until the transfer happens
      do @(posedge clock); while (req_stall);
      if (present || last)
         items_sent++;
   endtask

   task automatic wait_all_digests();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_message(input int len, input bit end_with_byte);
      int i;
      for (i = 0; i < len; i++) begin
         // drop an empty transfer in now and then
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(pick_byte(), 1'b1, end_with_byte && (i == len - 1));
      end
      if (!end_with_byte || len == 0)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      messages_sent++;
   endtask

   function automatic int pick_length();
      int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      case ($urandom_range(0, 9))
         6, 7: return edges[$urandom_range(0, 7)];
         8: return $urandom_range(13, 130);
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_data_byte      <= 8'h00;
      req_byte_present   <= 1'b0;
      req_end_of_message <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty transfer, empty message, "abc" closed by its last byte
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // one-byte messages: byte with end, and byte then bare end
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      wait_all_digests();

      while (items_sent < 260 || messages_sent < 12) begin
         send_message(pick_length(), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0)
            wait_all_digests();
      end

      wait_all_digests();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && words_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
